@@ hdl/pmhf_pkg.sv @@
// Shared constants and codes for the peak meter with hold and falloff.
`default_nettype none

package pmhf_pkg;

  // Width of every result field
  localparam int unsigned OutW = 24;
  localparam logic [OutW-1:0] OutMax = {OutW{1'b1}};

  // Fader gain is unsigned Q2.14, decay is unsigned Q0.16
  localparam int unsigned GainW    = 16;
  localparam int unsigned GainFrac = 14;
  localparam int unsigned DecayW   = 16;
  localparam int unsigned HoldW    = 10;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFaderGain    = 2'd0,
    CfgHoldFrames   = 2'd1,
    CfgDecayPerFrame = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ModeSample = 1'b0,
    ModeClear  = 1'b1
  } mode_e;

  localparam logic [GainW-1:0]  FaderGainRst = 16'd16384;
  localparam logic [HoldW-1:0]  HoldFramesRst = 10'd24;
  localparam logic [DecayW-1:0] DecayRst = 16'd63217;

endpackage

`default_nettype wire

@@ hdl/pmhf_if.sv @@
// Request channels of the peak meter: sample requests, results, configuration writes.
`default_nettype none

interface pmhf_smp_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          last_of_frame;

  modport source (output valid, mode, left_sample, right_sample, last_of_frame,
                  input ready);
  modport sink   (input valid, mode, left_sample, right_sample, last_of_frame,
                  output ready);
endinterface

interface pmhf_res_if;
  logic                         valid;
  logic                         ready;
  logic [pmhf_pkg::OutW-1:0]    level_left;
  logic [pmhf_pkg::OutW-1:0]    level_right;
  logic [pmhf_pkg::OutW-1:0]    held_left;
  logic [pmhf_pkg::OutW-1:0]    held_right;
  logic [pmhf_pkg::OutW-1:0]    all_time_peak;

  modport source (output valid, level_left, level_right, held_left, held_right,
                  all_time_peak, input ready);
  modport sink   (input valid, level_left, level_right, held_left, held_right,
                  all_time_peak, output ready);
endinterface

interface pmhf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pmhf_pkg::CfgIdxW-1:0]    index;
  logic [pmhf_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/peak_meter_hold_falloff_unit.sv @@
// Stereo peak meter with frame gain, peak hold, falloff and all-time peak.
`default_nettype none

// Takes one sample request per clock and gives one result per frame end. From the input
// register a frame-end request passes the frame peak stage, the gain multiply stage and
// the hold/falloff stage into the result register. The rate of one request per cycle is
// set by the frame peak register, which is read and written once per request, and by
// the held-peak state, which takes one frame end per cycle together with the falloff
// multiply. A clear request travels the same stages so it takes effect in order and
// gives no result. Stages move on independently, so requests that do not end a frame
// keep entering while a result waits in the output register; the input stalls only
// when a frame-end or clear request in the input register finds the stages behind it
// full. Configuration is always ready and must be written while the meter is idle.
module peak_meter_hold_falloff_unit #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned AGE_BITS    = 10
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  pmhf_smp_if.sink         smp_i,
  pmhf_res_if.source       res_o,
  pmhf_cfg_if.sink         cfg_i
);

  localparam int unsigned OutW  = pmhf_pkg::OutW;
  localparam int unsigned PkW   = SAMPLE_BITS - 1;
  localparam int unsigned ProdW = PkW + pmhf_pkg::GainW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned ScW   = SumW - pmhf_pkg::GainFrac;
  localparam int unsigned ExtW  = (ScW > OutW) ? ScW : OutW + 1;
  localparam int unsigned AgeCmpW = (AGE_BITS > pmhf_pkg::HoldW) ? AGE_BITS
                                                                  : pmhf_pkg::HoldW;
  localparam int unsigned DecProdW = OutW + pmhf_pkg::DecayW;
  localparam logic [PkW-1:0] MagMax = {PkW{1'b1}};
  localparam logic [SumW-1:0] RoundHalf = SumW'(1) << (pmhf_pkg::GainFrac - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [pmhf_pkg::GainW-1:0]  gain_q;
  logic [pmhf_pkg::HoldW-1:0]  hold_q;
  logic [pmhf_pkg::DecayW-1:0] decay_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= pmhf_pkg::FaderGainRst;
      hold_q  <= pmhf_pkg::HoldFramesRst;
      decay_q <= pmhf_pkg::DecayRst;
    end else if (cfg_i.valid) begin
      unique case (pmhf_pkg::cfg_idx_e'(cfg_i.index))
        pmhf_pkg::CfgFaderGain:     gain_q  <= cfg_i.data[pmhf_pkg::GainW-1:0];
        pmhf_pkg::CfgHoldFrames:    hold_q  <= cfg_i.data[pmhf_pkg::HoldW-1:0];
        pmhf_pkg::CfgDecayPerFrame: decay_q <= cfg_i.data[pmhf_pkg::DecayW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake
  // ---------------------------------------------------------------------------
  logic s0_vld_q, s1_vld_q, s2_vld_q, res_vld_q;
  logic s0_fwd, s0_fire, s1_fire, s2_fire;
  logic s0_free, s1_free, s2_free, out_free;
  logic s1_clr_q, s2_clr_q;

  assign out_free = !res_vld_q || res_o.ready;
  assign s2_fire  = s2_vld_q && (s2_clr_q || out_free);
  assign s2_free  = !s2_vld_q || s2_fire;
  assign s1_fire  = s1_vld_q && s2_free;
  assign s1_free  = !s1_vld_q || s1_fire;
  assign s0_fire  = s0_vld_q && (!s0_fwd || s1_free);
  assign s0_free  = !s0_vld_q || s0_fire;

  assign smp_i.ready = s0_free;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                   s0_mode_q, s0_last_q;
  logic [SAMPLE_BITS-1:0] s0_smp_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (s0_free) begin
      s0_vld_q <= smp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_free && smp_i.valid) begin
      s0_mode_q   <= smp_i.mode;
      s0_last_q   <= smp_i.last_of_frame;
      s0_smp_q[0] <= smp_i.left_sample;
      s0_smp_q[1] <= smp_i.right_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame peak stage
  // ---------------------------------------------------------------------------
  logic                   s0_clr;
  logic [PkW-1:0]         frame_peak_q [2];
  logic [PkW-1:0]         peak_new [2];
  logic [SAMPLE_BITS-1:0] neg_smp [2];
  logic [PkW-1:0]         mag [2];
  logic [PkW-1:0]         s1_peak_q [2];

  assign s0_clr = (pmhf_pkg::mode_e'(s0_mode_q) == pmhf_pkg::ModeClear);
  assign s0_fwd = s0_clr || s0_last_q;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      neg_smp[c] = -s0_smp_q[c];
      if (!s0_smp_q[c][SAMPLE_BITS-1]) begin
        mag[c] = s0_smp_q[c][PkW-1:0];
      end else if (neg_smp[c][SAMPLE_BITS-1]) begin
        // most negative code has no positive twin
        mag[c] = MagMax;
      end else begin
        mag[c] = neg_smp[c][PkW-1:0];
      end
      peak_new[c] = (mag[c] > frame_peak_q[c]) ? mag[c] : frame_peak_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_peak_q[0] <= '0;
      frame_peak_q[1] <= '0;
      s1_vld_q        <= 1'b0;
    end else begin
      if (s0_fire) begin
        for (int c = 0; c < 2; c++) begin
          frame_peak_q[c] <= s0_fwd ? '0 : peak_new[c];
        end
      end
      if (s1_free) begin
        s1_vld_q <= s0_fire && s0_fwd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && s0_fire && s0_fwd) begin
      s1_clr_q     <= s0_clr;
      s1_peak_q[0] <= peak_new[0];
      s1_peak_q[1] <= peak_new[1];
    end
  end

  // ---------------------------------------------------------------------------
  // Gain stage: round half up, saturate to the result width
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] gain_prod [2];
  logic [SumW-1:0]  gain_sum [2];
  logic [ExtW-1:0]  gain_ext [2];
  logic [OutW-1:0]  level [2];
  logic [OutW-1:0]  s2_lvl_q [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      gain_prod[c] = ProdW'(s1_peak_q[c]) * ProdW'(gain_q);
      gain_sum[c]  = SumW'(gain_prod[c]) + RoundHalf;
      gain_ext[c]  = ExtW'(gain_sum[c][SumW-1:pmhf_pkg::GainFrac]);
      level[c]     = (gain_ext[c] > ExtW'(pmhf_pkg::OutMax)) ? pmhf_pkg::OutMax
                                                              : gain_ext[c][OutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_free) begin
      s2_vld_q <= s1_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_fire) begin
      s2_clr_q    <= s1_clr_q;
      s2_lvl_q[0] <= level[0];
      s2_lvl_q[1] <= level[1];
    end
  end

  // ---------------------------------------------------------------------------
  // Hold and falloff stage
  // ---------------------------------------------------------------------------
  logic [OutW-1:0]     held_q [2];
  logic [OutW-1:0]     fall_q [2];
  logic [AGE_BITS-1:0] age_q [2];
  logic [OutW-1:0]     run_max_q;

  logic                holding [2];
  logic                replace [2];
  logic [OutW-1:0]     shown [2];
  logic [OutW-1:0]     disp [2];
  logic [DecProdW-1:0] dec_prod [2];
  logic [OutW-1:0]     fall_d [2];
  logic [AGE_BITS-1:0] age_d [2];
  logic [OutW-1:0]     run_mid, run_max_d;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      holding[c]  = AgeCmpW'(age_q[c]) < AgeCmpW'(hold_q);
      shown[c]    = holding[c] ? held_q[c] : fall_q[c];
      replace[c]  = s2_lvl_q[c] > shown[c];
      disp[c]     = replace[c] ? s2_lvl_q[c] : shown[c];
      dec_prod[c] = DecProdW'(fall_q[c]) * DecProdW'(decay_q);
      if (replace[c]) begin
        fall_d[c] = s2_lvl_q[c];
        age_d[c]  = '0;
      end else begin
        // fall only once the hold has run out; age stops at its limit
        fall_d[c] = holding[c] ? fall_q[c] : dec_prod[c][DecProdW-1:pmhf_pkg::DecayW];
        age_d[c]  = (&age_q[c]) ? age_q[c] : age_q[c] + AGE_BITS'(1);
      end
    end
    run_mid   = (s2_lvl_q[0] > run_max_q) ? s2_lvl_q[0] : run_max_q;
    run_max_d = (s2_lvl_q[1] > run_mid) ? s2_lvl_q[1] : run_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        held_q[c] <= '0;
        fall_q[c] <= '0;
        age_q[c]  <= '0;
      end
      run_max_q <= '0;
    end else if (s2_fire) begin
      if (s2_clr_q) begin
        for (int c = 0; c < 2; c++) begin
          held_q[c] <= '0;
          fall_q[c] <= '0;
          age_q[c]  <= '0;
        end
        run_max_q <= '0;
      end else begin
        for (int c = 0; c < 2; c++) begin
          if (replace[c]) begin
            held_q[c] <= s2_lvl_q[c];
          end
          fall_q[c] <= fall_d[c];
          age_q[c]  <= age_d[c];
        end
        run_max_q <= run_max_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [OutW-1:0] res_lvl_q [2];
  logic [OutW-1:0] res_held_q [2];
  logic [OutW-1:0] res_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (s2_fire && !s2_clr_q) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && !s2_clr_q) begin
      res_lvl_q[0]  <= s2_lvl_q[0];
      res_lvl_q[1]  <= s2_lvl_q[1];
      res_held_q[0] <= disp[0];
      res_held_q[1] <= disp[1];
      res_max_q     <= run_max_d;
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.level_left    = res_lvl_q[0];
  assign res_o.level_right   = res_lvl_q[1];
  assign res_o.held_left     = res_held_q[0];
  assign res_o.held_right    = res_held_q[1];
  assign res_o.all_time_peak = res_max_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_clear_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s2_clr_q) |=> (run_max_q == '0))
    else $error("all-time peak not cleared");

  a_fall_le_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fall_q[0] <= held_q[0]) && (fall_q[1] <= held_q[1]))
    else $error("falling peak above held peak");

  a_level_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> ((res_lvl_q[0] <= res_max_q) && (res_lvl_q[1] <= res_max_q)))
    else $error("frame level above all-time peak");

endmodule

`default_nettype wire
